/* rtl/swarq_pkg.sv */
// ----------------------------------------------------------------------------
// swarq_pkg
// Shared types and constants of the stop-and-wait ARQ engine.
// ----------------------------------------------------------------------------
package swarq_pkg;

  localparam int QUEUE_DEPTH     = 16;
  localparam int IDX_BITS        = $clog2(QUEUE_DEPTH);
  localparam int CNT_BITS        = $clog2(QUEUE_DEPTH + 1);
  localparam int SEQ_BITS        = 16;
  localparam int HANDLE_BITS     = 16;
  localparam int RETRY_BITS      = 4;
  localparam int CFG_INDEX_BITS  = 1;
  localparam int CFG_DATA_BITS   = 16;

  localparam logic [RETRY_BITS-1:0] RETRY_MAX       = '1;
  localparam logic [RETRY_BITS-1:0] RETRY_LIMIT_RST = RETRY_BITS'(10);

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_INITIAL_SEQNO = 1'b0,
    CFG_RETRY_LIMIT   = 1'b1
  } cfg_index_t;

  typedef enum logic [1:0] {
    MODE_TX    = 2'd0,
    MODE_ACK   = 2'd1,
    MODE_DATA  = 2'd2,
    MODE_TIMER = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    KIND_NUMBERED      = 3'd0,
    KIND_TRANSMIT      = 3'd1,
    KIND_DISCARD       = 3'd2,
    KIND_FULL          = 3'd3,
    KIND_ACK_MATCH     = 3'd4,
    KIND_ACK_UNKNOWN   = 3'd5,
    KIND_DELIVER_ACK   = 3'd6,
    KIND_DELIVER_NOACK = 3'd7
  } kind_t;

  typedef enum logic [1:0] {
    TCMD_NONE    = 2'd0,
    TCMD_RESTART = 2'd1,
    TCMD_STOP    = 2'd2
  } tcmd_t;

  typedef enum logic [1:0] {
    RD_NONE,
    RD_PTR,
    RD_PTR1,
    RD_FRONT
  } rd_sel_t;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_NEW,
    WR_SHIFT,
    WR_BUMP
  } wr_op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_CMP_RD,
    S_CMP_WR,
    S_POST_RM,
    S_SEND_RD,
    S_SEND_CHK,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic [SEQ_BITS-1:0]    seq;
    logic [HANDLE_BITS-1:0] handle;
    logic [RETRY_BITS-1:0]  retries;
  } entry_t;

  typedef struct packed {
    logic    ld_in;
    logic    ptr_clr;
    logic    ptr_inc;
    rd_sel_t rd_sel;
    wr_op_t  wr_op;
    logic    cnt_dec;
    logic    arm_set;
    logic    arm_clr;
    logic    out_ld;
    kind_t   out_kind;
    logic    out_last;
    tcmd_t   out_tcmd;
  } cmd_t;

  typedef struct packed {
    mode_t mode;
    logic  has_src;
    logic  armed;
    logic  full;
    logic  cnt_zero;
    logic  cnt_one;
    logic  srch_end;
    logic  cmp_end;
    logic  match;
    logic  front_over;
  } stat_t;

endpackage

/* rtl/swarq_if.sv */
// ----------------------------------------------------------------------------
// swarq_in_if / swarq_out_if
// Valid/ready channels carrying input events and result beats.
// ----------------------------------------------------------------------------
interface swarq_in_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        mode;
  logic [swarq_pkg::HANDLE_BITS-1:0] packet_handle;
  logic [swarq_pkg::SEQ_BITS-1:0]    rx_seqno;
  logic                              has_source;

  modport source(output valid, mode, packet_handle, rx_seqno, has_source, input ready);
  modport sink(input valid, mode, packet_handle, rx_seqno, has_source, output ready);
endinterface

interface swarq_out_if;
  logic                              valid;
  logic                              ready;
  logic [2:0]                        kind;
  logic [swarq_pkg::SEQ_BITS-1:0]    seqno;
  logic [swarq_pkg::HANDLE_BITS-1:0] out_handle;
  logic [1:0]                        timer_cmd;
  logic                              last;

  modport source(output valid, kind, seqno, out_handle, timer_cmd, last, input ready);
  modport sink(input valid, kind, seqno, out_handle, timer_cmd, last, output ready);
endinterface

/* rtl/swarq_dp.sv */
// ----------------------------------------------------------------------------
// swarq_dp
// Datapath: retransmit queue memory, counters, timer flag, result register.
// ----------------------------------------------------------------------------
module swarq_dp (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [swarq_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [swarq_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  input  logic [1:0]                            in_mode,
  input  logic [swarq_pkg::HANDLE_BITS-1:0]     in_handle,
  input  logic [swarq_pkg::SEQ_BITS-1:0]        in_rx_seqno,
  input  logic                                  in_has_source,
  input  swarq_pkg::cmd_t                       cmd,
  output swarq_pkg::stat_t                      stat,
  output logic [2:0]                            out_kind,
  output logic [swarq_pkg::SEQ_BITS-1:0]        out_seqno,
  output logic [swarq_pkg::HANDLE_BITS-1:0]     out_handle,
  output logic [1:0]                            out_tcmd,
  output logic                                  out_last
);

  swarq_pkg::entry_t mem [swarq_pkg::QUEUE_DEPTH];
  swarq_pkg::entry_t rd_data;
  swarq_pkg::entry_t wr_data;
  logic [swarq_pkg::IDX_BITS-1:0]    rd_addr;
  logic [swarq_pkg::IDX_BITS-1:0]    wr_addr;
  logic [swarq_pkg::CNT_BITS-1:0]    count;
  logic [swarq_pkg::CNT_BITS-1:0]    ptr;
  logic [swarq_pkg::CNT_BITS-1:0]    ptr1;
  logic [swarq_pkg::SEQ_BITS-1:0]    next_seqno;
  logic [swarq_pkg::SEQ_BITS-1:0]    seq_new;
  logic [swarq_pkg::RETRY_BITS-1:0]  retry_limit;
  logic [swarq_pkg::RETRY_BITS-1:0]  lim_eff;
  logic                              armed;
  swarq_pkg::mode_t                  mode;
  logic [swarq_pkg::HANDLE_BITS-1:0] handle;
  logic [swarq_pkg::SEQ_BITS-1:0]    rx_seqno;
  logic                              has_src;

  assign seq_new = next_seqno + 1'b1;
  assign ptr1    = ptr + 1'b1;
  // a zero limit behaves as one
  assign lim_eff = (retry_limit == '0) ? swarq_pkg::RETRY_BITS'(1) : retry_limit;

  always_ff @(posedge clk) begin
    if (cmd.ld_in) begin
      mode     <= swarq_pkg::mode_t'(in_mode);
      handle   <= in_handle;
      rx_seqno <= in_rx_seqno;
      has_src  <= in_has_source;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      next_seqno  <= '0;
      retry_limit <= swarq_pkg::RETRY_LIMIT_RST;
    end else begin
      if (cfg_we && cfg_index == swarq_pkg::CFG_INITIAL_SEQNO) begin
        next_seqno <= cfg_data[swarq_pkg::SEQ_BITS-1:0];
      end else if (cmd.wr_op == swarq_pkg::WR_NEW) begin
        next_seqno <= seq_new;
      end
      if (cfg_we && cfg_index == swarq_pkg::CFG_RETRY_LIMIT) begin
        retry_limit <= cfg_data[swarq_pkg::RETRY_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      armed <= 1'b0;
      ptr   <= '0;
    end else begin
      if (cmd.wr_op == swarq_pkg::WR_NEW) begin
        count <= count + 1'b1;
      end else if (cmd.cnt_dec) begin
        count <= count - 1'b1;
      end
      if (cmd.arm_set) begin
        armed <= 1'b1;
      end else if (cmd.arm_clr) begin
        armed <= 1'b0;
      end
      if (cmd.ptr_clr) begin
        ptr <= '0;
      end else if (cmd.ptr_inc) begin
        ptr <= ptr1;
      end
    end
  end

  always_comb begin
    rd_addr = '0;
    case (cmd.rd_sel)
      swarq_pkg::RD_PTR:   rd_addr = ptr[swarq_pkg::IDX_BITS-1:0];
      swarq_pkg::RD_PTR1:  rd_addr = ptr1[swarq_pkg::IDX_BITS-1:0];
      swarq_pkg::RD_FRONT: rd_addr = '0;
      default:             rd_addr = '0;
    endcase
  end

  always_comb begin
    wr_addr = '0;
    wr_data = rd_data;
    case (cmd.wr_op)
      swarq_pkg::WR_NEW: begin
        wr_addr = count[swarq_pkg::IDX_BITS-1:0];
        wr_data = '{seq: seq_new, handle: handle, retries: '0};
      end
      swarq_pkg::WR_SHIFT: begin
        wr_addr = ptr[swarq_pkg::IDX_BITS-1:0];
        wr_data = rd_data;
      end
      swarq_pkg::WR_BUMP: begin
        wr_addr = '0;
        wr_data = rd_data;
        if (rd_data.retries != swarq_pkg::RETRY_MAX) begin
          wr_data.retries = rd_data.retries + 1'b1;
        end
      end
      default: begin
        wr_addr = '0;
        wr_data = rd_data;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_op != swarq_pkg::WR_NONE) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_sel != swarq_pkg::RD_NONE) begin
      rd_data <= mem[rd_addr];
    end
  end

  // result register, held while the beat waits
  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      out_kind <= cmd.out_kind;
      out_tcmd <= cmd.out_tcmd;
      out_last <= cmd.out_last;
      case (cmd.out_kind)
        swarq_pkg::KIND_NUMBERED: begin
          out_seqno  <= seq_new;
          out_handle <= handle;
        end
        swarq_pkg::KIND_FULL: begin
          out_seqno  <= '0;
          out_handle <= handle;
        end
        swarq_pkg::KIND_ACK_MATCH: begin
          out_seqno  <= rx_seqno;
          out_handle <= rd_data.handle;
        end
        swarq_pkg::KIND_TRANSMIT, swarq_pkg::KIND_DISCARD: begin
          out_seqno  <= rd_data.seq;
          out_handle <= rd_data.handle;
        end
        default: begin
          out_seqno  <= rx_seqno;
          out_handle <= '0;
        end
      endcase
    end
  end

  always_comb begin
    stat.mode       = mode;
    stat.has_src    = has_src;
    stat.armed      = armed;
    stat.full       = (count == swarq_pkg::CNT_BITS'(swarq_pkg::QUEUE_DEPTH));
    stat.cnt_zero   = (count == '0);
    stat.cnt_one    = (count == swarq_pkg::CNT_BITS'(1));
    stat.srch_end   = (ptr >= count);
    stat.cmp_end    = (ptr1 >= count);
    stat.match      = (rd_data.seq == rx_seqno);
    stat.front_over = (rd_data.retries >= lim_eff);
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= swarq_pkg::CNT_BITS'(swarq_pkg::QUEUE_DEPTH))
    else $error("queue count above depth");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_op == swarq_pkg::WR_NEW |-> !stat.full)
    else $error("push into full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    cmd.cnt_dec |-> !stat.cnt_zero)
    else $error("pop from empty queue");

endmodule

/* rtl/swarq_ctrl.sv */
// ----------------------------------------------------------------------------
// swarq_ctrl
// Controller: sequences search, compaction, resend and result beats.
// ----------------------------------------------------------------------------
module swarq_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  swarq_pkg::stat_t stat,
  output swarq_pkg::cmd_t  cmd
);

  swarq_pkg::state_t state, state_next;
  swarq_pkg::state_t ret, ret_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= swarq_pkg::S_IDLE;
      ret   <= swarq_pkg::S_IDLE;
    end else begin
      state <= state_next;
      ret   <= ret_next;
    end
  end

  always_comb begin
    state_next = state;
    ret_next   = ret;
    case (state)
      swarq_pkg::S_IDLE: begin
        if (in_valid) state_next = swarq_pkg::S_DISPATCH;
      end
      swarq_pkg::S_DISPATCH: begin
        case (stat.mode)
          swarq_pkg::MODE_TX: begin
            state_next = swarq_pkg::S_EMIT;
            ret_next   = (!stat.full && stat.cnt_zero) ? swarq_pkg::S_SEND_RD
                                                       : swarq_pkg::S_IDLE;
          end
          swarq_pkg::MODE_ACK: state_next = swarq_pkg::S_SRCH_RD;
          swarq_pkg::MODE_DATA: begin
            state_next = swarq_pkg::S_EMIT;
            ret_next   = swarq_pkg::S_IDLE;
          end
          default: begin
            state_next = (stat.armed && !stat.cnt_zero) ? swarq_pkg::S_SEND_RD
                                                        : swarq_pkg::S_IDLE;
          end
        endcase
      end
      swarq_pkg::S_SRCH_RD: begin
        if (stat.srch_end) begin
          state_next = swarq_pkg::S_EMIT;
          ret_next   = swarq_pkg::S_IDLE;
        end else begin
          state_next = swarq_pkg::S_SRCH_CMP;
        end
      end
      swarq_pkg::S_SRCH_CMP: begin
        if (stat.match) begin
          state_next = swarq_pkg::S_EMIT;
          ret_next   = swarq_pkg::S_CMP_RD;
        end else begin
          state_next = swarq_pkg::S_SRCH_RD;
        end
      end
      swarq_pkg::S_CMP_RD: begin
        state_next = stat.cmp_end ? swarq_pkg::S_POST_RM : swarq_pkg::S_CMP_WR;
      end
      swarq_pkg::S_CMP_WR:  state_next = swarq_pkg::S_CMP_RD;
      // count already reflects the removal here
      swarq_pkg::S_POST_RM: begin
        state_next = stat.cnt_zero ? swarq_pkg::S_IDLE : swarq_pkg::S_SEND_RD;
      end
      swarq_pkg::S_SEND_RD:  state_next = swarq_pkg::S_SEND_CHK;
      swarq_pkg::S_SEND_CHK: begin
        state_next = swarq_pkg::S_EMIT;
        ret_next   = stat.front_over ? swarq_pkg::S_CMP_RD : swarq_pkg::S_IDLE;
      end
      swarq_pkg::S_EMIT: begin
        if (out_ready) state_next = ret;
      end
      default: state_next = swarq_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.rd_sel   = swarq_pkg::RD_NONE;
    cmd.wr_op    = swarq_pkg::WR_NONE;
    cmd.out_kind = swarq_pkg::KIND_NUMBERED;
    cmd.out_tcmd = swarq_pkg::TCMD_NONE;
    in_ready     = 1'b0;
    out_valid    = 1'b0;
    case (state)
      swarq_pkg::S_IDLE: begin
        in_ready  = 1'b1;
        cmd.ld_in = in_valid;
      end
      swarq_pkg::S_DISPATCH: begin
        cmd.ptr_clr = 1'b1;
        case (stat.mode)
          swarq_pkg::MODE_TX: begin
            cmd.out_ld = 1'b1;
            if (stat.full) begin
              cmd.out_kind = swarq_pkg::KIND_FULL;
              cmd.out_last = 1'b1;
            end else begin
              cmd.wr_op    = swarq_pkg::WR_NEW;
              cmd.out_kind = swarq_pkg::KIND_NUMBERED;
              cmd.out_last = !stat.cnt_zero;
            end
          end
          swarq_pkg::MODE_ACK: cmd.ptr_clr = 1'b1;
          swarq_pkg::MODE_DATA: begin
            cmd.out_ld   = 1'b1;
            cmd.out_last = 1'b1;
            cmd.out_kind = stat.has_src ? swarq_pkg::KIND_DELIVER_ACK
                                        : swarq_pkg::KIND_DELIVER_NOACK;
          end
          default: cmd.arm_clr = 1'b1;
        endcase
      end
      swarq_pkg::S_SRCH_RD: begin
        if (stat.srch_end) begin
          cmd.out_ld   = 1'b1;
          cmd.out_kind = swarq_pkg::KIND_ACK_UNKNOWN;
          cmd.out_last = 1'b1;
        end else begin
          cmd.rd_sel = swarq_pkg::RD_PTR;
        end
      end
      swarq_pkg::S_SRCH_CMP: begin
        if (stat.match) begin
          // removing the only entry ends the input, disarms the timer and stops it if armed
          cmd.out_ld   = 1'b1;
          cmd.out_kind = swarq_pkg::KIND_ACK_MATCH;
          cmd.out_last = stat.cnt_one;
          cmd.arm_clr  = stat.cnt_one;
          cmd.out_tcmd = (stat.cnt_one && stat.armed) ? swarq_pkg::TCMD_STOP
                                                      : swarq_pkg::TCMD_NONE;
        end else begin
          cmd.ptr_inc = 1'b1;
        end
      end
      swarq_pkg::S_CMP_RD: begin
        if (stat.cmp_end) cmd.cnt_dec = 1'b1;
        else cmd.rd_sel = swarq_pkg::RD_PTR1;
      end
      swarq_pkg::S_CMP_WR: begin
        cmd.wr_op   = swarq_pkg::WR_SHIFT;
        cmd.ptr_inc = 1'b1;
      end
      swarq_pkg::S_SEND_RD: begin
        cmd.rd_sel = swarq_pkg::RD_FRONT;
      end
      swarq_pkg::S_SEND_CHK: begin
        cmd.out_ld = 1'b1;
        if (stat.front_over) begin
          cmd.ptr_clr  = 1'b1;
          cmd.out_kind = swarq_pkg::KIND_DISCARD;
          cmd.out_last = stat.cnt_one;
          cmd.arm_clr  = stat.cnt_one;
          cmd.out_tcmd = (stat.cnt_one && stat.armed) ? swarq_pkg::TCMD_STOP
                                                      : swarq_pkg::TCMD_NONE;
        end else begin
          cmd.wr_op    = swarq_pkg::WR_BUMP;
          cmd.arm_set  = 1'b1;
          cmd.out_kind = swarq_pkg::KIND_TRANSMIT;
          cmd.out_last = 1'b1;
          cmd.out_tcmd = swarq_pkg::TCMD_RESTART;
        end
      end
      swarq_pkg::S_EMIT: out_valid = 1'b1;
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while busy");

  a_emit_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(ret))
    else $error("result beat dropped while stalled");

  a_ready_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input taken while a result waits");

endmodule

/* rtl/stop_and_wait_arq_engine.sv */
// ----------------------------------------------------------------------------
// stop_and_wait_arq_engine
// Stop-and-wait ARQ: numbering, retransmit queue, ack matching, timeouts.
// ----------------------------------------------------------------------------
// the input beat is registered; each result is then built in the result register
// ack handling walks the 16-entry queue memory: it reads and compares each
// entry searched, and reads and writes each entry shifted on removal
// a timer expiry that discards the front entry shifts the queue
// every result beat waits through output stalls; one item at a time
// reset (synchronous, active high) empties the queue, disarms the timer,
// zeroes the sequence counter and sets the retry limit to 10
module stop_and_wait_arq_engine (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [swarq_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [swarq_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  swarq_in_if.sink                             in_ch,
  swarq_out_if.source                          out_ch
);

  swarq_pkg::cmd_t  cmd;
  swarq_pkg::stat_t stat;

  swarq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  swarq_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_mode       (in_ch.mode),
    .in_handle     (in_ch.packet_handle),
    .in_rx_seqno   (in_ch.rx_seqno),
    .in_has_source (in_ch.has_source),
    .cmd           (cmd),
    .stat          (stat),
    .out_kind      (out_ch.kind),
    .out_seqno     (out_ch.seqno),
    .out_handle    (out_ch.out_handle),
    .out_tcmd      (out_ch.timer_cmd),
    .out_last      (out_ch.last)
  );

endmodule

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the stop-and-wait ARQ engine. A predictor tracks
// the retransmit queue, sequence counter and timer arming, and checks every
// result beat. Directed events come first, then random traffic under
// several valid/ready idling phases and register settings.
// ----------------------------------------------------------------------------
module tb;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    swarq_pkg::kind_t kind;
    logic [15:0]      seqno;
    logic [15:0]      handle;
    swarq_pkg::tcmd_t tcmd;
    logic             last;
  } beat_t;

  typedef struct {
    logic [15:0] seq;
    logic [15:0] handle;
    logic [3:0]  retries;
  } pend_t;

  class arq_predictor;
    logic [15:0] seq_ctr;
    logic [3:0]  retry_lim;
    pend_t       unacked[$];
    bit          armed;
    beat_t       expected_beats[$];
    beat_t       cur[$];
    int          errors;

    function void clear();
      seq_ctr = '0;
      retry_lim = swarq_pkg::RETRY_LIMIT_RST;
      unacked.delete();
      armed = 0;
      expected_beats.delete();
      errors = 0;
    endfunction

    function void write_reg(swarq_pkg::cfg_index_t idx, logic [15:0] v);
      if (idx == swarq_pkg::CFG_INITIAL_SEQNO) seq_ctr = v;
      else retry_lim = v[3:0];
    endfunction

    function void add(swarq_pkg::kind_t k, logic [15:0] s, logic [15:0] h,
                      swarq_pkg::tcmd_t t);
      beat_t b;
      if (cur.size() >= 4) return;
      b.kind = k; b.seqno = s; b.handle = h; b.tcmd = t; b.last = 0;
      cur = {cur, b};
    endfunction

    function void resend_front();
      logic [3:0] lim;
      lim = (retry_lim == 0) ? 4'd1 : retry_lim;
      while (unacked.size() > 0 && unacked[0].retries >= lim) begin
        add(swarq_pkg::KIND_DISCARD, unacked[0].seq, unacked[0].handle,
            swarq_pkg::TCMD_NONE);
        unacked.delete(0);
      end
      if (unacked.size() > 0) begin
        add(swarq_pkg::KIND_TRANSMIT, unacked[0].seq, unacked[0].handle,
            swarq_pkg::TCMD_RESTART);
        if (unacked[0].retries != swarq_pkg::RETRY_MAX) unacked[0].retries++;
        armed = 1;
      end else if (armed) begin
        armed = 0;
        if (cur.size() > 0) cur[cur.size()-1].tcmd = swarq_pkg::TCMD_STOP;
      end
    endfunction

    function void note_event(swarq_pkg::mode_t m, logic [15:0] h, logic [15:0] rx,
                             logic src);
      pend_t p;
      int    hit;
      cur.delete();
      case (m)
        swarq_pkg::MODE_TX: begin
          if (unacked.size() >= swarq_pkg::QUEUE_DEPTH) begin
            add(swarq_pkg::KIND_FULL, '0, h, swarq_pkg::TCMD_NONE);
          end else begin
            seq_ctr++;
            p.seq = seq_ctr; p.handle = h; p.retries = '0;
            unacked = {unacked, p};
            add(swarq_pkg::KIND_NUMBERED, seq_ctr, h, swarq_pkg::TCMD_NONE);
            if (unacked.size() == 1) resend_front();
          end
        end
        swarq_pkg::MODE_ACK: begin
          hit = -1;
          foreach (unacked[i]) if (hit < 0 && unacked[i].seq == rx) hit = i;
          if (hit >= 0) begin
            add(swarq_pkg::KIND_ACK_MATCH, rx, unacked[hit].handle,
                swarq_pkg::TCMD_NONE);
            unacked.delete(hit);
            resend_front();
          end else begin
            add(swarq_pkg::KIND_ACK_UNKNOWN, rx, '0, swarq_pkg::TCMD_NONE);
          end
        end
        swarq_pkg::MODE_DATA:
          add(src ? swarq_pkg::KIND_DELIVER_ACK : swarq_pkg::KIND_DELIVER_NOACK,
              rx, '0, swarq_pkg::TCMD_NONE);
        default: begin
          if (armed) begin
            armed = 0;
            resend_front();
          end
        end
      endcase
      if (cur.size() > 0) cur[cur.size()-1].last = 1;
      foreach (cur[i]) expected_beats = {expected_beats, cur[i]};
    endfunction

    function void check_beat(logic [2:0] k, logic [15:0] s, logic [15:0] h,
                             logic [1:0] t, logic l);
      beat_t e;
      if (expected_beats.size() == 0) begin
        $error("unexpected beat: kind %0d seqno %h handle %h", k, s, h);
        errors++;
        return;
      end
      e = expected_beats[0];
      expected_beats.delete(0);
      if (k !== e.kind) begin
        $error("kind: expected %0d, actual %0d", e.kind, k); errors++;
      end
      if (s !== e.seqno) begin
        $error("seqno: expected %h, actual %h", e.seqno, s); errors++;
      end
      if (h !== e.handle) begin
        $error("out_handle: expected %h, actual %h", e.handle, h); errors++;
      end
      if (t !== e.tcmd) begin
        $error("timer_cmd: expected %0d, actual %0d", e.tcmd, t); errors++;
      end
      if (l !== e.last) begin
        $error("last: expected %0d, actual %0d", e.last, l); errors++;
      end
    endfunction
  endclass

  logic                   clk = 0;
  logic                   rst;
  logic                   cfg_we;
  swarq_pkg::cfg_index_t  cfg_index;
  logic [15:0]            cfg_data;

  swarq_in_if  in_ch();
  swarq_out_if out_ch();

  stop_and_wait_arq_engine i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_ch    (in_ch.sink),
    .out_ch   (out_ch.source)
  );

  arq_predictor pred = new();
  int send_idle_pct;
  int recv_stall_pct;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  initial begin
    #10ms;
    $display("CHECK FAILED");
    $finish;
  end

  // receiver: check accepted beats, then pick ready for the next edge
  initial begin
    out_ch.ready <= 0;
    forever begin
      @(posedge clk);
      if (!rst && out_ch.valid && out_ch.ready)
        pred.check_beat(out_ch.kind, out_ch.seqno, out_ch.out_handle,
                        out_ch.timer_cmd, out_ch.last);
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic send_event(swarq_pkg::mode_t m, logic [15:0] h, logic [15:0] rx,
                            logic src);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct && gap < 40) gap++;
    if (gap > 0) begin
      in_ch.valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1;
    in_ch.mode <= m;
    in_ch.packet_handle <= h;
    in_ch.rx_seqno <= rx;
    in_ch.has_source <= src;
    do @(posedge clk); while (!in_ch.ready);
    pred.note_event(m, h, rx, src);
  endtask

  // lower valid, drain all expected beats, then allow for trailing work
  task automatic settle();
    int n;
    in_ch.valid <= 0;
    n = 0;
    while (pred.expected_beats.size() > 0 && n < 200000) begin
      @(posedge clk);
      n++;
    end
    if (pred.expected_beats.size() > 0) begin
      $display("CHECK FAILED");
      $finish;
    end
    repeat (100) @(posedge clk);
  endtask

  // cfg_we is dropped again after each write, keeping back-to-back writes apart
  task automatic write_reg(swarq_pkg::cfg_index_t idx, logic [15:0] v);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 0;
    pred.write_reg(idx, v);
    @(posedge clk);
  endtask

  task automatic random_event();
    int    pick;
    logic [15:0] rx;
    pick = $urandom_range(99);
    rx = 16'($urandom);
    if (pick < 35) begin
      send_event(swarq_pkg::MODE_TX, 16'($urandom), rx, 1'($urandom));
    end else if (pick < 65) begin
      // mostly acks for packets still outstanding
      if (pred.unacked.size() > 0 && $urandom_range(99) < 75)
        rx = pred.unacked[$urandom_range(pred.unacked.size()-1)].seq;
      send_event(swarq_pkg::MODE_ACK, 16'($urandom), rx, 1'($urandom));
    end else if (pick < 80) begin
      send_event(swarq_pkg::MODE_DATA, 16'($urandom), rx, 1'($urandom));
    end else begin
      send_event(swarq_pkg::MODE_TIMER, 16'($urandom), rx, 1'($urandom));
    end
  endtask

  initial begin
    rst = 1;
    cfg_we <= 0;
    cfg_index <= swarq_pkg::CFG_INITIAL_SEQNO;
    cfg_data <= '0;
    in_ch.valid <= 0;
    in_ch.mode <= swarq_pkg::MODE_TX;
    in_ch.packet_handle <= '0;
    in_ch.rx_seqno <= '0;
    in_ch.has_source <= 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    pred.clear();
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: wrap of the counter, non-front ack, retry discard
    write_reg(swarq_pkg::CFG_INITIAL_SEQNO, 16'hfffe);
    write_reg(swarq_pkg::CFG_RETRY_LIMIT, 16'h0002);
    send_event(swarq_pkg::MODE_TIMER, 16'h0000, 16'h0000, 0);
    send_event(swarq_pkg::MODE_DATA, 16'h0000, 16'hffff, 1);
    send_event(swarq_pkg::MODE_DATA, 16'hffff, 16'h0000, 0);
    send_event(swarq_pkg::MODE_TX, 16'h0000, 16'h0000, 0);
    send_event(swarq_pkg::MODE_TX, 16'hffff, 16'hffff, 1);
    send_event(swarq_pkg::MODE_ACK, 16'h0000, 16'h0000, 0);
    send_event(swarq_pkg::MODE_TIMER, 16'h0000, 16'h0000, 0);
    send_event(swarq_pkg::MODE_TIMER, 16'h0000, 16'h0000, 0);
    send_event(swarq_pkg::MODE_TIMER, 16'h0000, 16'h0000, 0);
    send_event(swarq_pkg::MODE_ACK, 16'h0000, 16'h1234, 1);
    // fill the queue and overflow it
    for (int i = 0; i < swarq_pkg::QUEUE_DEPTH + 1; i++)
      send_event(swarq_pkg::MODE_TX, 16'($urandom), 16'($urandom), 1'($urandom));

    for (int ph = 0; ph < 4; ph++) begin
      settle();
      case (ph)
        0: begin
          write_reg(swarq_pkg::CFG_INITIAL_SEQNO, 16'h0000);
          write_reg(swarq_pkg::CFG_RETRY_LIMIT, 16'hfff0);
          send_idle_pct = 0; recv_stall_pct = 0;
        end
        1: begin
          write_reg(swarq_pkg::CFG_INITIAL_SEQNO, 16'hffff);
          write_reg(swarq_pkg::CFG_RETRY_LIMIT, 16'h000f);
          send_idle_pct = 61; recv_stall_pct = 0;
        end
        2: begin
          write_reg(swarq_pkg::CFG_INITIAL_SEQNO, 16'($urandom));
          write_reg(swarq_pkg::CFG_RETRY_LIMIT, 16'h0001);
          send_idle_pct = 0; recv_stall_pct = 61;
        end
        default: begin
          write_reg(swarq_pkg::CFG_INITIAL_SEQNO, 16'($urandom));
          write_reg(swarq_pkg::CFG_RETRY_LIMIT,
                    {12'($urandom), 4'($urandom_range(15, 1))});
          send_idle_pct = 38; recv_stall_pct = 38;
        end
      endcase
      for (int i = 0; i < 46; i++) random_event();
    end

    settle();
    if (pred.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

/* sim.f */
rtl/swarq_pkg.sv
rtl/swarq_if.sv
rtl/swarq_dp.sv
rtl/swarq_ctrl.sv
rtl/stop_and_wait_arq_engine.sv
tb/tb.sv
